// ----- hdl/stk_pkg.sv -----
// Shared types and constants for the sorted top-k insertion table.
package stk_pkg;

   localparam int TAG_W               = 24;
   localparam int POINTS_W            = 31;
   localparam int RANK_W              = 7;
   localparam int FILL_W              = 8;
   localparam int DEFAULT_TABLE_DEPTH = 128;

   // One offered record; also the content of one table cell.
   typedef struct packed {
      logic [TAG_W-1:0]    player_tag;
      logic [POINTS_W-1:0] points;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [RANK_W-1:0] rank;
      logic [FILL_W-1:0] fill_count;
   } rsp_type;

endpackage

// ----- hdl/stk_cell.sv -----
// One table cell: holds an entry, compares it to the offered record and shifts.
module stk_cell import stk_pkg::*; (
   input  logic    clock,
   input  logic    load,
   input  logic    valid,
   input  req_type new_entry,
   input  logic    prev_greater,
   input  req_type prev_entry,
   output logic    greater,
   output req_type entry,
   output logic    flag
);

   req_type entry_ff, entry_in;
   logic    flag_ff;

   assign greater = valid && (entry_ff.points > new_entry.points);

   always_comb begin
      entry_in = entry_ff;
      if (!greater) begin
         // the first cell not outscoring the record takes it, those after shift down
         entry_in = prev_greater ? new_entry : prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
         flag_ff  <= greater;
      end
   end

   assign entry = entry_ff;
   assign flag  = flag_ff;

endmodule

// ----- hdl/stk_rank.sv -----
// Rank search: finds the length of the leading run of set flags, one bit per cycle.
module stk_rank import stk_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [TABLE_DEPTH-1:0]             flags,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]   pos,
   output logic                               done
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int BIT_W = $clog2(CNT_W);

   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             run_ff, run_in;
   logic [CNT_W-1:0] trial;
   logic [CNT_W-1:0] trial_less;
   logic             hit;

   // flags form a thermometer, so a binary search over the run length works
   assign trial      = pos_ff | (CNT_W'(1) << bit_ff);
   assign trial_less = trial - CNT_W'(1);
   assign hit        = (trial <= CNT_W'(TABLE_DEPTH)) && flags[trial_less[IDX_W-1:0]];

   always_comb begin
      pos_in = pos_ff;
      bit_in = bit_ff;
      run_in = run_ff;
      if (load) begin
         pos_in = '0;
         bit_in = BIT_W'(CNT_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (hit) begin
            pos_in = trial;
         end
         if (bit_ff == '0) begin
            run_in = 1'b0;
         end else begin
            bit_in = bit_ff - BIT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      pos_ff <= pos_in;
      bit_ff <= bit_in;
   end

   assign pos  = pos_ff;
   assign done = run_ff && (bit_ff == '0);

endmodule

// ----- hdl/sorted_top_k_insert_table_core.sv -----
// Top level of the sorted top-k insertion table: cell chain, rank search, control.
// An accepted request runs the bit-serial rank search (state SEARCH, busy high), and
// the result is shown in state RESPOND; the receiver cannot stall it. No request is
// taken while the search runs, so the bit-serial rank search sets the request rate;
// a new request may be taken in the cycle the result is shown.
// Reset (synchronous, active high) empties the table; entry contents are not cleared.
module sorted_top_k_insert_table_core import stk_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_SEARCH  = 3'b010,
      ST_RESPOND = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accepted_ff;
   logic             accept;
   logic             rejected;

   logic [TABLE_DEPTH-1:0] greater_w;
   logic [TABLE_DEPTH-1:0] flag_w;
   logic [TABLE_DEPTH-1:0] valid_w;
   req_type                entry_w [TABLE_DEPTH];

   logic [CNT_W-1:0] pos;
   logic             search_done;

   // Hold off requests only while the rank search runs.
   assign busy   = (state_ff == ST_SEARCH);
   assign accept = start && !busy;

   // The record is dropped when even the last cell outscores it (table full).
   assign rejected = greater_w[TABLE_DEPTH-1];

   // Cell chain: cell 0 has nothing above it, so it sees an outscoring neighbor.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign valid_w[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         stk_cell u_cell (
            .clock       (clock),
            .load        (accept),
            .valid       (valid_w[i]),
            .new_entry   (req_data),
            .prev_greater(1'b1),
            .prev_entry  (req_data),
            .greater     (greater_w[i]),
            .entry       (entry_w[i]),
            .flag        (flag_w[i])
         );
      end else begin : g_body
         stk_cell u_cell (
            .clock       (clock),
            .load        (accept),
            .valid       (valid_w[i]),
            .new_entry   (req_data),
            .prev_greater(greater_w[i-1]),
            .prev_entry  (entry_w[i-1]),
            .greater     (greater_w[i]),
            .entry       (entry_w[i]),
            .flag        (flag_w[i])
         );
      end
   end

   // Rank = number of cells that outscored the record, found from the captured flags.
   stk_rank #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_rank (
      .clock(clock),
      .reset(reset),
      .load (accept),
      .flags(flag_w),
      .pos  (pos),
      .done (search_done)
   );

   // Fill count: advance on every placed record until the table is full.
   always_comb begin
      count_in = count_ff;
      if (accept && !rejected && (count_ff != CNT_W'(TABLE_DEPTH))) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (search_done) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = accept ? ST_SEARCH : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      if (accept) begin
         accepted_ff <= !rejected;
      end
   end

   // Drive the result for the single respond cycle; rank reads zero on a reject.
   assign rsp_strobe          = (state_ff == ST_RESPOND);
   assign rsp_data.accepted   = accepted_ff;
   assign rsp_data.rank       = accepted_ff ? RANK_W'(pos) : '0;
   assign rsp_data.fill_count = FILL_W'(count_ff);

endmodule

// ----- hdl/stk_checker.sv -----
// Port-level checks for the sorted top-k insertion table, bound to the top level.
module stk_checker import stk_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_reject_rank: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.accepted) |-> (rsp_data.rank == '0))
      else $error("rejected request reported a nonzero rank");

endmodule

bind sorted_top_k_insert_table_core stk_checker u_stk_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_strobe(rsp_strobe),
   .rsp_data  (rsp_data)
);

// ----- tb/sv/sorted_top_k_insert_table_monitor.sv -----
// Checker for the top-k insertion table: predicts each result and compares it.
module sorted_top_k_insert_table_monitor import stk_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      checked_count,
   output int      refused_count,
   output int      tie_count
);

   localparam int PRINT_LIMIT = 40;

   logic [POINTS_W-1:0] ranked_points [TABLE_DEPTH];
   logic [TAG_W-1:0]    ranked_tags [TABLE_DEPTH];
   int                  held_entries;
   rsp_type             awaited_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      refused_count = 0;
      tie_count     = 0;
      held_entries  = 0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (fail_count < PRINT_LIMIT)
         $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                  checked_count, what, got, want);
      fail_count++;
   endtask

   // Insert below every strictly higher score; drop the last entry when full.
   task automatic place_record(input req_type offer, output rsp_type outcome);
      int slot;
      int last;
      slot = 0;
      while (slot < held_entries && ranked_points[slot] > offer.points)
         slot++;
      if (slot >= TABLE_DEPTH) begin
         outcome.accepted   = 1'b0;
         outcome.rank       = '0;
         outcome.fill_count = FILL_W'(held_entries);
         refused_count++;
      end else begin
         if (slot < held_entries && ranked_points[slot] == offer.points)
            tie_count++;
         last = (held_entries < TABLE_DEPTH) ? held_entries : TABLE_DEPTH - 1;
         for (int i = last; i > slot; i--) begin
            ranked_points[i] = ranked_points[i-1];
            ranked_tags[i]   = ranked_tags[i-1];
         end
         ranked_points[slot] = offer.points;
         ranked_tags[slot]   = offer.player_tag;
         if (held_entries < TABLE_DEPTH)
            held_entries++;
         outcome.accepted   = 1'b1;
         outcome.rank       = RANK_W'(slot);
         outcome.fill_count = FILL_W'(held_entries);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type outcome;
      if (reset) begin
         held_entries = 0;
         awaited_results.delete();
      end else begin
         // Compare first: a result may leave in the cycle a new request enters.
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with no request pending", rsp_data, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.accepted !== want.accepted)
                  report_mismatch("accepted", rsp_data.accepted, want.accepted);
               if (rsp_data.rank !== want.rank)
                  report_mismatch("rank", rsp_data.rank, want.rank);
               if (rsp_data.fill_count !== want.fill_count)
                  report_mismatch("fill_count", rsp_data.fill_count, want.fill_count);
               checked_count++;
            end
         end
         if (start && !busy) begin
            place_record(req_data, outcome);
            awaited_results.push_back(outcome);
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

// ----- tb/sv/sorted_top_k_insert_table_core_test.sv -----
// Testbench top for the top-k insertion table: clock, reset, requests and verdict.
module sorted_top_k_insert_table_core_test;
   import stk_pkg::*;

   localparam int DIRECTED_COUNT = 14;
   localparam int RANDOM_COUNT   = 1000;
   // Cycles with neither a request nor a result taken before giving up.
   localparam int QUIET_LIMIT    = 2000;
   localparam int RECENT_SIZE    = 32;
   localparam logic [POINTS_W-1:0] TOP_POINTS = '1;

   // Score classes for random requests.
   typedef enum {
      SCORE_CLIMB,
      SCORE_REPEAT,
      SCORE_LOW,
      SCORE_EDGE,
      SCORE_ANY
   } score_kind_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;
   int refused_count;
   int tie_count;

   int idle_pct = 34;
   int quiet_cycles = 0;

   // Recently offered scores, reused to force ties anywhere in the table.
   logic [POINTS_W-1:0] recent_points [RECENT_SIZE];
   int                  recent_next = 0;
   int                  recent_fill = 0;
   // Slowly rising base, so that many requests land near the top of a full table.
   logic [POINTS_W-1:0] climb_base = '0;

   always #2 clock = ~clock;

   sorted_top_k_insert_table_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   sorted_top_k_insert_table_monitor score_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .refused_count (refused_count),
      .tie_count     (tie_count)
   );

   // Watchdog: restart the count on any accepted request or result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles", QUIET_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Directed requests: empty table, ties at the top, bottom and middle,
   // field extremes and alternating bit patterns.
   function automatic req_type directed_offer(input int n);
      req_type r;
      case (n)
         0:  r = '{player_tag: 24'h000000, points: '0};         // first entry, empty table
         1:  r = '{player_tag: 24'hFFFFFF, points: TOP_POINTS};  // new top
         2:  r = '{player_tag: 24'h414243, points: TOP_POINTS};  // tie at the top
         3:  r = '{player_tag: 24'h5A5A5A, points: '0};         // tie at the bottom
         4:  r = '{player_tag: 24'hA5A5A5, points: 31'h55555555};
         5:  r = '{player_tag: 24'h555555, points: 31'h2AAAAAAA};
         6:  r = '{player_tag: 24'hAAAAAA, points: 31'h40000000};
         7:  r = '{player_tag: 24'h123456, points: 31'h40000000}; // tie in the middle
         8:  r = '{player_tag: 24'h800001, points: 31'h00000001};
         9:  r = '{player_tag: 24'h7FFFFE, points: TOP_POINTS - 1'b1};
         10: r = '{player_tag: 24'hFEDCBA, points: 31'h3FFFFFFF};
         11: r = '{player_tag: 24'h0F0F0F, points: 31'h2AAAAAAA};
         12: r = '{player_tag: 24'hF0F0F0, points: '0};
         default: r = '{player_tag: 24'hFFFFFF, points: TOP_POINTS};
      endcase
      return r;
   endfunction

   // Random request: a mix of rising scores, repeats, low values, edges and
   // uniform draws, so the full table both accepts and refuses records.
   function automatic req_type random_offer();
      req_type        r;
      score_kind_type kind;
      int             pick;
      pick = $urandom_range(99);
      if (pick < 25)
         kind = SCORE_CLIMB;
      else if (pick < 50)
         kind = SCORE_REPEAT;
      else if (pick < 65)
         kind = SCORE_LOW;
      else if (pick < 75)
         kind = SCORE_EDGE;
      else
         kind = SCORE_ANY;
      if (kind == SCORE_REPEAT && recent_fill == 0)
         kind = SCORE_LOW;
      case (kind)
         SCORE_CLIMB: begin
            climb_base = climb_base + POINTS_W'($urandom_range(1 << 20));
            r.points   = climb_base + POINTS_W'($urandom_range(3));
         end
         SCORE_REPEAT: r.points = recent_points[$urandom_range(recent_fill - 1)];
         SCORE_LOW:    r.points = POINTS_W'($urandom_range(31));
         SCORE_EDGE: begin
            case ($urandom_range(3))
               0:       r.points = '0;
               1:       r.points = TOP_POINTS;
               2:       r.points = POINTS_W'(1);
               default: r.points = TOP_POINTS - 1'b1;
            endcase
         end
         default:      r.points = POINTS_W'($urandom);
      endcase
      case ($urandom_range(9))
         0:       r.player_tag = '0;
         1:       r.player_tag = '1;
         default: r.player_tag = TAG_W'($urandom);
      endcase
      recent_points[recent_next] = r.points;
      recent_next = (recent_next + 1) % RECENT_SIZE;
      if (recent_fill < RECENT_SIZE)
         recent_fill++;
      return r;
   endfunction

   // Offer one request: maybe idle first, then hold start until busy is low
   // at a rising edge. Start stays high into the next request when no idle
   // gap is drawn.
   task automatic offer_request(input req_type offer);
      logic [63:0] junk;
      if ($urandom_range(99) < idle_pct) begin
         junk = {$urandom, $urandom};
         start    <= 1'b0;
         req_data <= junk[$bits(req_type)-1:0];
         @(posedge clock);
         while ($urandom_range(99) < idle_pct)
            @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= offer;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_COUNT; n++)
         offer_request(directed_offer(n));

      // Sender idles 34 percent, then 47 percent, then never.
      for (n = 0; n < RANDOM_COUNT; n++) begin
         if (n == RANDOM_COUNT / 3)
            idle_pct = 47;
         else if (n == 2 * RANDOM_COUNT / 3)
            idle_pct = 0;
         offer_request(random_offer());
      end
      start <= 1'b0;

      // Drain: wait out every pending result before reporting.
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Offered %0d records (%0d directed, %0d random); %0d results checked.",
               DIRECTED_COUNT + RANDOM_COUNT, DIRECTED_COUNT, RANDOM_COUNT, checked_count);
      $display("Refused on a full table: %0d; placed ahead of an equal score: %0d.",
               refused_count, tie_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sorted_top_k_insert_table_core.f -----
hdl/stk_pkg.sv
hdl/stk_cell.sv
hdl/stk_rank.sv
hdl/sorted_top_k_insert_table_core.sv
hdl/stk_checker.sv
tb/sv/sorted_top_k_insert_table_monitor.sv
tb/sv/sorted_top_k_insert_table_core_test.sv
